// File: design/scsort_pkg.sv
// Package for the stable counting sort index unit: item types, defaults and states.
`default_nettype none
package scsort_pkg;

  localparam int NUM_KEYS_DEF    = 128;
  localparam int MAX_RECORDS_DEF = 64;
  localparam int OFFSET_BITS_DEF = 16;

  localparam int SORT_KEY_W = 7;
  localparam int OFFSET_W   = 16;

  typedef struct packed {
    logic [SORT_KEY_W-1:0] sort_key;
    logic [OFFSET_W-1:0]   record_offset;
    logic                  final_record;
  } in_item_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] sorted_offset;
    logic                final_result;
    logic                overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_KEY_RD,
    ST_KEY_CHK,
    ST_REC_CHK,
    ST_TAIL
  } st_t;

endpackage
`default_nettype wire

// File: design/stable_counting_sort_index_unit.sv
// Top level of the stable counting sort index unit: bucket lists, load and emit sequencer.
`default_nettype none
// Usage
//   Input channel: an item {sort_key, record_offset, final_record} is taken at a rising
//   edge with start high and busy low. Keys at or above NUM_KEYS saturate to the top key.
//   Loading an item reads the key's bucket entry from the key RAM, then writes it back
//   (and links the previous tail in the record RAM); no new item is taken until the write.
//   Up to MAX_RECORDS items are stored per set; later ones are dropped and the overflow
//   flag is set on every result of that set.
//   An item with final_record set ends the set. The sequencer then walks all keys in
//   ascending order and follows each bucket's linked list, so records of equal key come
//   out in arrival order.
//   Output channel: each result sits on out_item for exactly one cycle with out_valid
//   high; final_result marks the last one. The receiver cannot stall the block.
//   busy stays high through the whole walk; the walk also clears the key RAM. The last
//   result can still be on out_item in the first cycle with busy low.
//   Reset: rst_n low (synchronous) restarts a clearing pass over every key RAM entry,
//   with busy high, before the first item is taken.
module stable_counting_sort_index_unit #(
  parameter int NUM_KEYS    = scsort_pkg::NUM_KEYS_DEF,
  parameter int MAX_RECORDS = scsort_pkg::MAX_RECORDS_DEF,
  parameter int OFFSET_BITS = scsort_pkg::OFFSET_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire scsort_pkg::in_item_t  in_item,
  output logic                       out_valid,
  output scsort_pkg::out_item_t      out_item
);

  import scsort_pkg::*;

  localparam int KEY_AW   = $clog2(NUM_KEYS);
  localparam int REC_AW   = $clog2(MAX_RECORDS);
  localparam int CNT_W    = $clog2(MAX_RECORDS + 1);
  localparam int CMP_W    = ((KEY_AW > SORT_KEY_W) ? KEY_AW : SORT_KEY_W) + 1;
  localparam int OFF_WIDE = (OFFSET_BITS > OFFSET_W) ? OFFSET_BITS : OFFSET_W;
  // key RAM entry: {valid, head, tail, tail offset}
  localparam int KENT_W   = 1 + 2 * REC_AW + OFFSET_BITS;
  // record RAM entry: {offset, next}
  localparam int RENT_W   = OFFSET_BITS + REC_AW;

  localparam logic [KEY_AW-1:0] KEY_LAST = KEY_AW'(NUM_KEYS - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(MAX_RECORDS);

  st_t state_r, state_nxt;

  logic [KEY_AW-1:0]      k_r, k_nxt;
  logic [KEY_AW-1:0]      key_in_r, key_in_nxt;
  logic [OFFSET_BITS-1:0] off_in_r, off_in_nxt;
  logic                   fin_in_r, fin_in_nxt;
  logic [CNT_W-1:0]       rec_cnt_r, rec_cnt_nxt;
  logic [CNT_W-1:0]       out_cnt_r, out_cnt_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [REC_AW-1:0]      tail_r, tail_nxt;
  logic [OFFSET_BITS-1:0] tail_off_r, tail_off_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  // key RAM
  logic               kwe;
  logic [KEY_AW-1:0]  kwaddr, kraddr;
  logic [KENT_W-1:0]  kwdata, krdata;
  logic               k_valid;
  logic [REC_AW-1:0]  k_head, k_tail;
  logic [OFFSET_BITS-1:0] k_toff;

  // record RAM
  logic               rwe;
  logic [REC_AW-1:0]  rwaddr, rraddr;
  logic [RENT_W-1:0]  rwdata, rrdata;
  logic [OFFSET_BITS-1:0] r_off;
  logic [REC_AW-1:0]  r_next;

  // input formatting
  logic [CMP_W-1:0]    key_ext;
  logic [KEY_AW-1:0]   key_sat;
  logic [OFF_WIDE-1:0] off_in_wide;

  // misc control
  logic                   full;
  logic                   accept;
  logic [REC_AW-1:0]      rec_idx;
  logic                   emit;
  logic [OFFSET_BITS-1:0] emit_off;
  logic [OFF_WIDE-1:0]    emit_wide;
  logic                   emit_last;
  logic                   key_done;
  logic                   walk_end;

  assign {k_valid, k_head, k_tail, k_toff} = krdata;
  assign {r_off, r_next}                   = rrdata;

  assign key_ext     = CMP_W'(in_item.sort_key);
  assign key_sat     = (key_ext >= CMP_W'(NUM_KEYS)) ? KEY_LAST : key_ext[KEY_AW-1:0];
  assign off_in_wide = OFF_WIDE'(in_item.record_offset);

  assign full    = (rec_cnt_r == CNT_FULL);
  assign accept  = (state_r == ST_IDLE) && start;
  assign rec_idx = rec_cnt_r[REC_AW-1:0];
  assign busy    = (state_r != ST_IDLE);

  scsort_ram #(
    .DEPTH (NUM_KEYS),
    .WIDTH (KENT_W)
  ) u_key_ram (
    .clk   (clk),
    .we    (kwe),
    .waddr (kwaddr),
    .wdata (kwdata),
    .raddr (kraddr),
    .rdata (krdata)
  );

  scsort_ram #(
    .DEPTH (MAX_RECORDS),
    .WIDTH (RENT_W)
  ) u_rec_ram (
    .clk   (clk),
    .we    (rwe),
    .waddr (rwaddr),
    .wdata (rwdata),
    .raddr (rraddr),
    .rdata (rrdata)
  );

  // memory port control
  always_comb begin
    kwe    = 1'b0;
    kwaddr = k_r;
    kwdata = '0;
    rwe    = 1'b0;
    rwaddr = k_tail;
    rwdata = {k_toff, rec_idx};
    kraddr = (state_r == ST_IDLE) ? key_sat : k_r;
    rraddr = (state_r == ST_KEY_CHK) ? k_head : r_next;
    unique case (state_r)
      ST_CLEAR: begin
        kwe = 1'b1;
      end
      ST_LOAD: begin
        // append record to its key's list; the old tail gets its next pointer
        kwe    = !full;
        kwaddr = key_in_r;
        kwdata = {1'b1, (k_valid ? k_head : rec_idx), rec_idx, off_in_r};
        rwe    = !full && k_valid;
      end
      ST_KEY_CHK: begin
        // entry is latched below; clear it for the next set
        kwe = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:   if (k_r == KEY_LAST) state_nxt = ST_IDLE;
      ST_IDLE:    if (start) state_nxt = ST_LOAD;
      ST_LOAD:    state_nxt = fin_in_r ? ST_KEY_RD : ST_IDLE;
      ST_KEY_RD:  state_nxt = ST_KEY_CHK;
      ST_KEY_CHK: begin
        if (k_valid && (k_head != k_tail)) begin
          state_nxt = ST_REC_CHK;
        end else begin
          state_nxt = (k_r == KEY_LAST) ? ST_IDLE : ST_KEY_RD;
        end
      end
      ST_REC_CHK: if (r_next == tail_r) state_nxt = ST_TAIL;
      ST_TAIL:    state_nxt = (k_r == KEY_LAST) ? ST_IDLE : ST_KEY_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // emit select
  always_comb begin
    emit     = 1'b0;
    emit_off = tail_off_r;
    key_done = 1'b0;
    unique case (state_r)
      ST_KEY_CHK: begin
        emit     = k_valid && (k_head == k_tail);
        emit_off = k_toff;
        key_done = !(k_valid && (k_head != k_tail));
      end
      ST_REC_CHK: begin
        emit     = 1'b1;
        emit_off = r_off;
      end
      ST_TAIL: begin
        emit     = 1'b1;
        key_done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign walk_end  = key_done && (k_r == KEY_LAST);
  assign emit_wide = OFF_WIDE'(emit_off);
  assign emit_last = (out_cnt_r == (rec_cnt_r - CNT_W'(1)));

  // datapath and counters
  always_comb begin
    k_nxt         = k_r;
    key_in_nxt    = key_in_r;
    off_in_nxt    = off_in_r;
    fin_in_nxt    = fin_in_r;
    rec_cnt_nxt   = rec_cnt_r;
    out_cnt_nxt   = out_cnt_r;
    ovf_nxt       = ovf_r;
    tail_nxt      = tail_r;
    tail_off_nxt  = tail_off_r;
    out_valid_nxt = emit;
    out_item_nxt.sorted_offset = emit_wide[OFFSET_W-1:0];
    out_item_nxt.final_result  = emit_last;
    out_item_nxt.overflow      = ovf_r;

    if (state_r == ST_CLEAR) begin
      k_nxt = k_r + KEY_AW'(1);
    end
    if (accept) begin
      key_in_nxt = key_sat;
      off_in_nxt = off_in_wide[OFFSET_BITS-1:0];
      fin_in_nxt = in_item.final_record;
    end
    if (state_r == ST_LOAD) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        rec_cnt_nxt = rec_cnt_r + CNT_W'(1);
      end
      k_nxt = '0;
    end
    if (state_r == ST_KEY_CHK) begin
      tail_nxt     = k_tail;
      tail_off_nxt = k_toff;
    end
    if (emit) begin
      out_cnt_nxt = out_cnt_r + CNT_W'(1);
    end
    if (key_done) begin
      k_nxt = k_r + KEY_AW'(1);
    end
    if (walk_end) begin
      // set finished: back to empty
      rec_cnt_nxt = '0;
      out_cnt_nxt = '0;
      ovf_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      k_r         <= '0;
      rec_cnt_r   <= '0;
      out_cnt_r   <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
      out_cnt_r   <= out_cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_in_r   <= key_in_nxt;
    off_in_r   <= off_in_nxt;
    fin_in_r   <= fin_in_nxt;
    tail_r     <= tail_nxt;
    tail_off_r <= tail_off_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// File: design/scsort_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`default_nettype none
module scsort_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: bench/scsort_index_checker.sv
// Checker for the stable counting sort index unit: watches both channels and predicts the sort.
`timescale 1ns / 1ps
module scsort_index_checker #(
  parameter int NUM_KEYS    = scsort_pkg::NUM_KEYS_DEF,
  parameter int MAX_RECORDS = scsort_pkg::MAX_RECORDS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire scsort_pkg::in_item_t  in_item,
  input  wire logic                  out_valid,
  input  wire scsort_pkg::out_item_t out_item,
  output int                         mismatches,
  output int                         pending
);
  import scsort_pkg::*;

  typedef struct {
    logic [SORT_KEY_W-1:0] key;
    logic [OFFSET_W-1:0]   offset;
  } record_t;

  record_t   loaded_records[$];   // current set, arrival order
  logic      set_dropped = 1'b0;
  out_item_t sorted_offsets[$];   // results still owed by the block

  // Bucket walk: ascending key, arrival order within a key.
  function automatic void emit_sorted_offsets();
    out_item_t res;
    int        first_new;
    first_new = sorted_offsets.size();
    for (int k = 0; k < NUM_KEYS; k++) begin
      foreach (loaded_records[r]) begin
        if (loaded_records[r].key == k) begin
          res.sorted_offset = loaded_records[r].offset;
          res.final_result  = 1'b0;
          res.overflow      = set_dropped;
          sorted_offsets.push_back(res);
        end
      end
    end
    if (sorted_offsets.size() > first_new)
      sorted_offsets[sorted_offsets.size() - 1].final_result = 1'b1;
    loaded_records.delete();
    set_dropped = 1'b0;
  endfunction

  function automatic void take_record(in_item_t item);
    record_t rec;
    int      k;
    k = int'(item.sort_key);
    if (k >= NUM_KEYS) k = NUM_KEYS - 1;
    rec.key    = k[SORT_KEY_W-1:0];
    rec.offset = item.record_offset;
    if (loaded_records.size() < MAX_RECORDS) loaded_records.push_back(rec);
    else set_dropped = 1'b1;
    // a dropped final record still closes the set
    if (item.final_record) emit_sorted_offsets();
  endfunction

  function automatic void report(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected offset %h final %b ovf %b, got offset %h final %b ovf %b",
               $realtime, what, want.sorted_offset, want.final_result, want.overflow,
               got.sorted_offset, got.final_result, got.overflow);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      loaded_records.delete();
      sorted_offsets.delete();
      set_dropped = 1'b0;
    end else begin
      if (out_valid) begin
        if (sorted_offsets.size() == 0) begin
          want = '0;
          report("unexpected result", want, out_item);
        end else begin
          want = sorted_offsets.pop_front();
          if (out_item.sorted_offset !== want.sorted_offset ||
              out_item.final_result !== want.final_result ||
              out_item.overflow !== want.overflow)
            report("result mismatch", want, out_item);
        end
      end
      if (start && !busy) take_record(in_item);
    end
    pending = sorted_offsets.size();
  end

endmodule

// File: bench/stable_counting_sort_index_unit_test.sv
// Testbench top for the stable counting sort index unit: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps
module stable_counting_sort_index_unit_test;
  import scsort_pkg::*;

  // Run limit: about a hundred items in a few dozen sets at most, each set with a full
  // walk of the key buckets and items sent in bursts with random idle gaps, fit well
  // inside it many times over.
  localparam int LIMIT        = 200000;
  // Quiet time after the last result: one full walk of the key buckets.
  localparam int TAIL_CYCLES  = 2 * NUM_KEYS_DEF + MAX_RECORDS_DEF + 16;
  localparam int RANDOM_ITEMS = 20;

  // Key spreads for random sets.
  localparam int KEYS_FULL = 0;   // whole key range
  localparam int KEYS_LOW  = 1;   // bottom four keys, many ties
  localparam int KEYS_HIGH = 2;   // top four keys, many ties

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int burst_left  = 0;   // items left in the current sender burst

  always #6 clk = ~clk;

  stable_counting_sort_index_unit #(
    .NUM_KEYS    (NUM_KEYS_DEF),
    .MAX_RECORDS (MAX_RECORDS_DEF),
    .OFFSET_BITS (OFFSET_BITS_DEF)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  scsort_index_checker #(
    .NUM_KEYS    (NUM_KEYS_DEF),
    .MAX_RECORDS (MAX_RECORDS_DEF)
  ) monitor (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Watchdog: covers a hung block or results that never show up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one item and hold it until start && !busy at an edge.
  // The sender runs in bursts; between bursts start drops for a random gap.
  // A zero gap keeps start high, so back-to-back stretches occur too.
  task automatic send_record(input logic [SORT_KEY_W-1:0] key,
                             input logic [OFFSET_W-1:0] offset, input logic last);
    in_item_t item;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    item.sort_key      = key;
    item.record_offset = offset;
    item.final_record  = last;
    in_item <= item;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    burst_left--;
  endtask

  // One complete set with random offsets; only the last item is flagged final.
  task automatic send_set(input int count, input int spread);
    logic [SORT_KEY_W-1:0] key;
    for (int i = 0; i < count; i++) begin
      case (spread)
        KEYS_LOW:  key = SORT_KEY_W'($urandom_range(0, 3));
        KEYS_HIGH: key = SORT_KEY_W'($urandom_range(NUM_KEYS_DEF - 4, NUM_KEYS_DEF - 1));
        default:   key = SORT_KEY_W'($urandom_range(0, NUM_KEYS_DEF - 1));
      endcase
      send_record(key, OFFSET_W'($urandom_range(0, 16'hFFFF)), i == count - 1);
    end
  endtask

  // Hold the sender off until every owed result has come out.
  // Pending is sampled at the falling edge, clear of the checker's update.
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int pick;
    int size;
    int random_sent;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-record sets at both key and offset extremes.
    send_record(7'd0, 16'h0000, 1'b1);
    send_record(7'd127, 16'hFFFF, 1'b1);
    wait_drained();

    // Mixed keys, out of order, with ties at the bottom key, at key 5 and at the top key.
    send_record(7'd127, 16'h0001, 1'b0);
    send_record(7'd0,   16'h8000, 1'b0);
    send_record(7'd5,   16'h1234, 1'b0);
    send_record(7'd0,   16'h0002, 1'b0);
    send_record(7'd127, 16'hAAAA, 1'b0);
    send_record(7'd5,   16'h5555, 1'b0);
    send_record(7'd64,  16'hFFFE, 1'b1);

    // One key only: output must keep arrival order, not offset order.
    send_record(7'd3, 16'h0004, 1'b0);
    send_record(7'd3, 16'h0003, 1'b0);
    send_record(7'd3, 16'h0002, 1'b0);
    send_record(7'd3, 16'h0001, 1'b1);

    // Capacity: a set that fills the store and spills over, so the final
    // item itself is dropped and overflow must be set.
    send_set(MAX_RECORDS_DEF + 2, KEYS_LOW);
    wait_drained();

    // Random sets: mostly small, some medium.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) size = $urandom_range(1, 8);
      else size = $urandom_range(9, 16);
      send_set(size, $urandom_range(KEYS_FULL, KEYS_HIGH));
      random_sent += size;
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    // Anything after this point is a stray result.
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: stable_counting_sort_index_unit.f
design/scsort_pkg.sv
design/scsort_ram.sv
design/stable_counting_sort_index_unit.sv
bench/scsort_index_checker.sv
bench/stable_counting_sort_index_unit_test.sv
